/* hdl/matrix_multiply_accumulate_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply-accumulate block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_ASSERT_SVH

// Plain property check
`define MMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: antecedent holds -> consequent holds in the same cycle
`define MMA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg
// Types and constants of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Default largest matrix dimension
  localparam int MaxDimDefault = 8;

  // Field widths
  localparam int DataW = 48;  // Q32.16 accumulator element
  localparam int QW    = 16;  // Q8.8 operand element
  localparam int ProdW = 2 * QW;
  localparam int AccW  = DataW + 2;  // headroom for C plus up to 16 products
  localparam int CfgW  = 4;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_LOAD_C = 2'd2,
    KIND_START  = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_M  = 2'd0,
    CFG_COLS_N  = 2'd1,
    CFG_INNER_K = 2'd2
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

endpackage

/* hdl/matrix_multiply_accumulate.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// C += A * B over matrices held in on-chip memories, fixed point.
//
// Input channel (in_valid_i / in_stall_o): one word per element load of A, B
// or C, or a start word. A load is accepted whenever the block is idle, also
// while results still wait at the output.
// A start word runs the product. For each C element the sequencer issues the
// A/B memory reads, one for each inner term, followed by the read, multiply
// and accumulate stages and then saturation and write-back. A start word thus
// keeps the input stalled until the last C element has been written back.
// Output channel (out_valid_o / out_stall_i): one word per C element in
// row-major order, last_o on the final one. A stalled output word holds and
// the sequencer waits before finishing the next element.
// Reset clears the C memory (per-entry valid bits, no clearing pass) and sets
// all dimensions to 8. A and B hold nothing until loaded. The user must change
// dimensions through the config port only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`include "matrix_multiply_accumulate_assert.svh"

module matrix_multiply_accumulate
  import mma_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config port
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic [2:0]              row_index_i,
  input  logic [2:0]              col_index_i,
  input  logic signed [DataW-1:0] element_value_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              out_row_o,
  output logic [2:0]              out_col_o,
  output logic signed [DataW-1:0] out_value_o,
  output logic                    saturated_o,
  output logic                    last_o
);

  localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CntW  = $clog2(MAX_DIM + 1);
  localparam int AddrW = 2 * IdxW;
  localparam int Depth = 1 << AddrW;

  // Config registers
  logic [CfgW-1:0] rows_m_q, cols_n_q, inner_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= CfgW'(8);
      cols_n_q  <= CfgW'(8);
      inner_k_q <= CfgW'(8);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS_M:  rows_m_q  <= cfg_data_i;
        CFG_COLS_N:  cols_n_q  <= cfg_data_i;
        CFG_INNER_K: inner_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, oversize clamps to MAX_DIM
  logic [CntW-1:0] m_use, n_use, k_use;

  always_comb begin
    m_use = (rows_m_q == '0) ? CntW'(1) :
            (int'(rows_m_q) > MAX_DIM) ? CntW'(MAX_DIM) : CntW'(rows_m_q);
    n_use = (cols_n_q == '0) ? CntW'(1) :
            (int'(cols_n_q) > MAX_DIM) ? CntW'(MAX_DIM) : CntW'(cols_n_q);
    k_use = (inner_k_q == '0) ? CntW'(1) :
            (int'(inner_k_q) > MAX_DIM) ? CntW'(MAX_DIM) : CntW'(inner_k_q);
  end

  // Input handshake and load decode
  state_e           state_q, state_d;
  logic             in_acc;
  logic             ld_ok;
  logic [IdxW+2:0]  ld_row_ext, ld_col_ext;
  logic [AddrW-1:0] ld_addr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_ok      = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);
  assign ld_row_ext = {IdxW'(0), row_index_i};
  assign ld_col_ext = {IdxW'(0), col_index_i};
  assign ld_addr    = {ld_row_ext[IdxW-1:0], ld_col_ext[IdxW-1:0]};

  // Sequencer counters
  logic [IdxW-1:0] i_q, j_q, l_q, i_d, j_d, l_d;
  logic            l_last, j_last, i_last, fin;
  logic            acc_done_q;
  logic            out_v_q;

  assign l_last = ((CntW'(l_q) + CntW'(1)) == k_use);
  assign j_last = ((CntW'(j_q) + CntW'(1)) == n_use);
  assign i_last = ((CntW'(i_q) + CntW'(1)) == m_use);

  // Next state and sequencing
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    l_d     = l_q;
    fin     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_i == KIND_START)) begin
          state_d = ST_ISSUE;
          i_d     = '0;
          j_d     = '0;
          l_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (l_last) begin
          l_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          l_d = l_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (acc_done_q && (!out_v_q || !out_stall_i)) begin
          fin = 1'b1;
          if (i_last && j_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + IdxW'(1);
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      l_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      l_q     <= l_d;
    end
  end

  // Memories: A, B operands and C accumulators
  logic [QW-1:0]    a_mem [Depth];
  logic [QW-1:0]    b_mem [Depth];
  logic [DataW-1:0] c_mem [Depth];
  logic [Depth-1:0] c_valid_q;

  logic signed [QW-1:0]    a_rd_q, b_rd_q;
  logic [DataW-1:0]        c_rd_q;
  logic                    cv_rd_q;
  logic [AddrW-1:0]        a_raddr, b_raddr, c_addr;
  logic                    c_we;
  logic [AddrW-1:0]        c_waddr;
  logic [DataW-1:0]        c_wdata;
  logic signed [DataW-1:0] sat_value;

  assign a_raddr = {i_q, l_q};
  assign b_raddr = {l_q, j_q};
  assign c_addr  = {i_q, j_q};
  assign c_we    = fin || (in_acc && (kind_i == KIND_LOAD_C) && ld_ok);
  assign c_waddr = fin ? c_addr : ld_addr;
  assign c_wdata = fin ? sat_value : element_value_i;

  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KIND_LOAD_A) && ld_ok) begin
      a_mem[ld_addr] <= element_value_i[QW-1:0];
    end
    if (in_acc && (kind_i == KIND_LOAD_B) && ld_ok) begin
      b_mem[ld_addr] <= element_value_i[QW-1:0];
    end
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    a_rd_q <= a_mem[a_raddr];
    b_rd_q <= b_mem[b_raddr];
    c_rd_q <= c_mem[c_addr];
  end

  // C valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= '0;
      cv_rd_q   <= 1'b0;
    end else begin
      if (c_we) begin
        c_valid_q[c_waddr] <= 1'b1;
      end
      cv_rd_q <= c_valid_q[c_addr];
    end
  end

  // Pipeline control: read stage, multiply stage, accumulate
  logic s1_v_q, s1_first_q, s1_last_q;
  logic s2_v_q, s2_first_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      s1_v_q     <= (state_q == ST_ISSUE);
      s1_first_q <= (state_q == ST_ISSUE) && (l_q == '0);
      s1_last_q  <= (state_q == ST_ISSUE) && l_last;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      if (fin) begin
        acc_done_q <= 1'b0;
      end else if (s2_v_q && s2_last_q) begin
        acc_done_q <= 1'b1;
      end
    end
  end

  // Datapath: product register, C base, accumulator
  logic signed [ProdW-1:0] prod_q;
  logic signed [DataW-1:0] cbase_q;
  logic signed [AccW-1:0]  acc_q, acc_d, acc_start;

  assign acc_start = s2_first_q ? {{(AccW-DataW){cbase_q[DataW-1]}}, cbase_q} : acc_q;
  assign acc_d     = acc_start + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_rd_q) * ProdW'(b_rd_q);
    if (s1_first_q) begin
      cbase_q <= cv_rd_q ? c_rd_q : '0;
    end
    if (s2_v_q) begin
      acc_q <= acc_d;
    end
  end

  // Saturation to the signed 48-bit range
  logic acc_ovf;

  assign acc_ovf   = !((&acc_q[AccW-1:DataW-1]) || !(|acc_q[AccW-1:DataW-1]));
  assign sat_value = !acc_ovf ? acc_q[DataW-1:0] :
                     acc_q[AccW-1] ? {1'b1, {(DataW-1){1'b0}}} :
                                     {1'b0, {(DataW-1){1'b1}}};

  // Output register
  logic [2:0]              out_row_q, out_col_q;
  logic signed [DataW-1:0] out_value_q;
  logic                    out_sat_q, out_last_q;
  logic [IdxW+2:0]         i_ext, j_ext;

  assign i_ext = {3'b000, i_q};
  assign j_ext = {3'b000, j_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_row_q   <= i_ext[2:0];
      out_col_q   <= j_ext[2:0];
      out_value_q <= sat_value;
      out_sat_q   <= acc_ovf;
      out_last_q  <= i_last && j_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

  // Checks
  `MMA_ASSERT_IMPL(a_done_pipe_empty, acc_done_q, !s1_v_q && !s2_v_q,
                   "accumulator done while products still in flight")
  `MMA_ASSERT_IMPL(a_issue_not_done, state_q == ST_ISSUE, !acc_done_q,
                   "stale accumulator result during issue")
  `MMA_ASSERT_IMPL(a_first_not_done, s2_v_q && s2_first_q, !acc_done_q,
                   "new element started before previous one finished")
  `MMA_ASSERT(a_run_ends_last,
              (state_q == ST_DRAIN) ##1 (state_q == ST_IDLE) |-> out_v_q && out_last_q,
              "run ended without a last word at the output")

endmodule

/* dv/matrix_multiply_accumulate_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the matrix multiply-accumulate block
// Follows the config port and the input channel to keep its own copy of the
// dimensions and of the A, B and C memories. On every accepted start word it
// computes the whole C run, and it compares each accepted output word with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_checker
  import mma_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config port
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              kind_i,
  input  logic [2:0]              row_i,
  input  logic [2:0]              col_i,
  input  logic signed [DataW-1:0] value_i,
  // output channel
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [2:0]              out_row_i,
  input  logic [2:0]              out_col_i,
  input  logic signed [DataW-1:0] out_value_i,
  input  logic                    saturated_i,
  input  logic                    last_i,
  // status
  output int                      error_count_o,
  output int                      pending_o
);

  localparam int     Dim         = MaxDimDefault;
  localparam int     Slots       = Dim * Dim;
  localparam longint MaxAcc      = 64'sh7FFF_FFFF_FFFF;
  localparam longint MinAcc      = -MaxAcc - 1;
  localparam int     ReportLimit = 10;

  typedef struct packed {
    logic [2:0]              row;
    logic [2:0]              col;
    logic signed [DataW-1:0] value;
    logic                    sat;
    logic                    last;
  } c_word_t;

  // Model memories, entry (row, col) at row * Dim + col
  logic signed [QW-1:0]    a_mem [Slots];
  logic signed [QW-1:0]    b_mem [Slots];
  logic signed [DataW-1:0] c_mem [Slots];
  logic [CfgW-1:0]         rows_reg;
  logic [CfgW-1:0]         cols_reg;
  logic [CfgW-1:0]         inner_reg;

  c_word_t c_words_due [$];
  c_word_t got;
  c_word_t want;
  int      errors;
  int      slot;

  // Register value 0 runs as 1, anything above Dim runs as Dim
  function automatic int dim_in_use(logic [CfgW-1:0] r);
    if (r == '0) return 1;
    if (r > Dim) return Dim;
    return int'(r);
  endfunction

  // C += A * B over the current sizes, saturated once per element
  task automatic predict_product();
    int      m, n, k, i, j, l, at;
    longint  acc;
    c_word_t w;
    m = dim_in_use(rows_reg);
    n = dim_in_use(cols_reg);
    k = dim_in_use(inner_reg);
    for (i = 0; i < m; i++) begin
      for (j = 0; j < n; j++) begin
        at  = i * Dim + j;
        acc = longint'(c_mem[at]);
        for (l = 0; l < k; l++) begin
          acc += longint'(a_mem[i * Dim + l]) * longint'(b_mem[l * Dim + j]);
        end
        w.sat = 1'b0;
        if (acc > MaxAcc) begin
          acc   = MaxAcc;
          w.sat = 1'b1;
        end else if (acc < MinAcc) begin
          acc   = MinAcc;
          w.sat = 1'b1;
        end
        c_mem[at] = DataW'(acc);
        w.row     = 3'(i);
        w.col     = 3'(j);
        w.value   = DataW'(acc);
        w.last    = (i == m - 1) && (j == n - 1);
        c_words_due.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (slot = 0; slot < Slots; slot++) begin
        a_mem[slot] = '0;
        b_mem[slot] = '0;
        c_mem[slot] = '0;
      end
      rows_reg  = CfgW'(Dim);
      cols_reg  = CfgW'(Dim);
      inner_reg = CfgW'(Dim);
      c_words_due.delete();
      errors        = 0;
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      // output word: compare against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = '{out_row_i, out_col_i, out_value_i, saturated_i, last_i};
        if (c_words_due.size() == 0) begin
          if (errors < ReportLimit)
            $display("%0t: unexpected C word row %0d col %0d value %0d sat %0b last %0b",
                     $realtime, got.row, got.col, got.value, got.sat, got.last);
          errors++;
        end else begin
          want = c_words_due.pop_front();
          if (got !== want) begin
            if (errors < ReportLimit)
              $display("%0t: C word mismatch: expected row %0d col %0d value %0d",
                       $realtime, want.row, want.col, want.value,
                       " sat %0b last %0b, got row %0d col %0d value %0d",
                       want.sat, want.last, got.row, got.col, got.value,
                       " sat %0b last %0b", got.sat, got.last);
            errors++;
          end
        end
      end

      // input word: store a load or run the product
      if (in_valid_i && !in_stall_i) begin
        slot = int'(row_i) * Dim + int'(col_i);
        case (kind_i)
          KIND_LOAD_A: a_mem[slot] = value_i[QW-1:0];
          KIND_LOAD_B: b_mem[slot] = value_i[QW-1:0];
          KIND_LOAD_C: c_mem[slot] = value_i;
          default:     predict_product();
        endcase
      end

      // config write; unknown index is ignored
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROWS_M:  rows_reg  = cfg_data_i;
          CFG_COLS_N:  cols_reg  = cfg_data_i;
          CFG_INNER_K: inner_reg = cfg_data_i;
          default: ;
        endcase
      end

      error_count_o = errors;
      pending_o     = c_words_due.size();
    end
  end

endmodule

/* dv/matrix_multiply_accumulate_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the matrix multiply-accumulate block
// Drives a short directed sequence (saturation both ways, accumulate again,
// loads outside the current sizes), then random load/start sequences over a
// list of dimension settings including 0 and values above the maximum. Both
// channels idle at random; one phase holds the output off for a long stretch.
// Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_tb;
  import mma_pkg::*;

  localparam int Dim          = MaxDimDefault;
  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 24;   // last load or write-back still in flight
  localparam int DrainCycles  = 64;
  localparam int IdleLimit    = 4000;
  localparam int HoldCycles   = 300;
  localparam int PhaseWords   = 20;
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam logic [DataW-1:0] MaxC = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinC = {1'b1, {(DataW-1){1'b0}}};

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [1:0]              cfg_index_i     = '0;
  logic [CfgW-1:0]         cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              kind_i          = '0;
  logic [2:0]              row_index_i     = '0;
  logic [2:0]              col_index_i     = '0;
  logic signed [DataW-1:0] element_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [2:0]              out_row_o;
  logic [2:0]              out_col_o;
  logic signed [DataW-1:0] out_value_o;
  logic                    saturated_o;
  logic                    last_o;

  int mismatch_count;
  int results_pending;

  // stimulus bookkeeping
  int               sender_max_gap   = 4;
  int               receiver_max_gap = 4;
  bit               hold_request     = 1'b0;
  logic [Dim*Dim-1:0] a_loaded       = '0;
  logic [Dim*Dim-1:0] b_loaded       = '0;
  int               m_used           = Dim;
  int               n_used           = Dim;
  int               k_used           = Dim;
  int               words_sent       = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_multiply_accumulate dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .saturated_o     (saturated_o),
    .last_o          (last_o)
  );

  matrix_multiply_accumulate_checker product_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .kind_i        (kind_i),
    .row_i         (row_index_i),
    .col_i         (col_index_i),
    .value_i       (element_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_i     (out_row_o),
    .out_col_i     (out_col_o),
    .out_value_i   (out_value_o),
    .saturated_i   (saturated_o),
    .last_i        (last_o),
    .error_count_o (mismatch_count),
    .pending_o     (results_pending)
  );

  function automatic int dim_in_use(logic [CfgW-1:0] r);
    if (r == '0) return 1;
    if (r > Dim) return Dim;
    return int'(r);
  endfunction

  function automatic logic [DataW-1:0] any_value();
    return DataW'({$urandom, $urandom});
  endfunction

  // Q8.8 operand in the low bits, junk above
  function automatic logic [DataW-1:0] operand_value();
    logic [DataW-1:0] v;
    v = any_value();
    case ($urandom_range(0, 5))
      0:       v[QW-1:0] = 16'h7FFF;
      1:       v[QW-1:0] = 16'h8000;
      default: ;
    endcase
    return v;
  endfunction

  // C start values: anywhere, near either rail, or small
  function automatic logic [DataW-1:0] accum_value();
    logic signed [31:0] s;
    s = $urandom;
    case ($urandom_range(0, 3))
      0:       return any_value();
      1:       return MaxC - $urandom_range(0, 1 << 20);
      2:       return MinC + $urandom_range(0, 1 << 20);
      default: return DataW'(s);
    endcase
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic offer_word(kind_e kind, int row, int col, logic [DataW-1:0] value);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i          <= kind;
    row_index_i     <= 3'(row);
    col_index_i     <= 3'(col);
    element_value_i <= value;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    words_sent++;
    if (kind == KIND_LOAD_A) a_loaded[row * Dim + col] = 1'b1;
    if (kind == KIND_LOAD_B) b_loaded[row * Dim + col] = 1'b1;
  endtask

  // A and B entries read by a start must have been loaded first
  task automatic start_product();
    int i, j, l;
    for (i = 0; i < m_used; i++)
      for (l = 0; l < k_used; l++)
        if (!a_loaded[i * Dim + l]) offer_word(KIND_LOAD_A, i, l, operand_value());
    for (l = 0; l < k_used; l++)
      for (j = 0; j < n_used; j++)
        if (!b_loaded[l * Dim + j]) offer_word(KIND_LOAD_B, l, j, operand_value());
    offer_word(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7), any_value());
  endtask

  // Load inside the current sizes
  task automatic load_in_range();
    case ($urandom_range(0, 2))
      0: offer_word(KIND_LOAD_A, $urandom_range(0, m_used - 1),
                    $urandom_range(0, k_used - 1), operand_value());
      1: offer_word(KIND_LOAD_B, $urandom_range(0, k_used - 1),
                    $urandom_range(0, n_used - 1), operand_value());
      default: offer_word(KIND_LOAD_C, $urandom_range(0, m_used - 1),
                          $urandom_range(0, n_used - 1), accum_value());
    endcase
  endtask

  // Drop valid, wait for every predicted word, then let the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One write per register, plus one to the unused index
  task automatic write_dims(logic [CfgW-1:0] rows, logic [CfgW-1:0] cols,
                            logic [CfgW-1:0] inner);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROWS_M;
    cfg_data_i  <= rows;
    @(negedge clk_i);
    cfg_index_i <= CFG_COLS_N;
    cfg_data_i  <= cols;
    @(negedge clk_i);
    cfg_index_i <= CFG_INNER_K;
    cfg_data_i  <= inner;
    @(negedge clk_i);
    cfg_index_i <= CfgUnused;
    cfg_data_i  <= CfgW'($urandom);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    m_used = dim_in_use(rows);
    n_used = dim_in_use(cols);
    k_used = dim_in_use(inner);
  endtask

  // Mostly load runs ending in a start, some stray loads anywhere
  task automatic run_phase(logic [CfgW-1:0] rows, logic [CfgW-1:0] cols,
                           logic [CfgW-1:0] inner, bit hold);
    int phase_start;
    wait_idle();
    write_dims(rows, cols, inner);
    sender_max_gap   = $urandom_range(0, 2) == 0 ? 0 : 4;
    receiver_max_gap = $urandom_range(0, 2) == 0 ? 0 : 4;
    hold_request     = hold;
    phase_start      = words_sent;
    while (words_sent - phase_start < PhaseWords) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 4)) load_in_range();
        start_product();
      end else begin
        offer_word(kind_e'($urandom_range(0, 2)), $urandom_range(0, 7),
                   $urandom_range(0, 7), any_value());
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: 1x1x1 corner cases
    write_dims(4'd1, 4'd1, 4'd1);
    offer_word(KIND_LOAD_A, 0, 0, {32'hFFFF_A5A5, 16'h7FFF});
    offer_word(KIND_LOAD_B, 0, 0, {32'h0000_5A5A, 16'h7FFF});
    offer_word(KIND_START, 0, 0, '0);          // C from reset zero
    offer_word(KIND_LOAD_C, 0, 0, MaxC);
    offer_word(KIND_START, 7, 7, '1);          // clamps high
    offer_word(KIND_START, 0, 0, '0);          // accumulates again, still clamped
    offer_word(KIND_LOAD_A, 0, 0, 48'h8000);
    offer_word(KIND_LOAD_C, 0, 0, MinC);
    offer_word(KIND_START, 3, 5, MaxC);        // clamps low
    offer_word(KIND_LOAD_B, 0, 0, 48'h8000);
    offer_word(KIND_LOAD_C, 0, 0, '0);
    offer_word(KIND_START, 0, 0, MinC);        // most negative squared
    // loads outside the current sizes are stored but not used
    offer_word(KIND_LOAD_A, 7, 7, 48'h1234);
    offer_word(KIND_LOAD_B, 7, 7, 48'hFFFF_FFFF_EDCB);
    offer_word(KIND_LOAD_C, 7, 7, 48'd123);
    offer_word(KIND_START, 0, 0, '0);

    // random: fixed settings first, then two drawn ones
    run_phase(4'd0, 4'd0, 4'd0, 1'b0);
    run_phase(4'd2, 4'd3, 4'd4, 1'b0);
    run_phase(4'd8, 4'd1, 4'd8, 1'b0);
    run_phase(4'd1, 4'd8, 4'd1, 1'b0);
    run_phase(4'd3, 4'd5, 4'd2, 1'b0);
    run_phase(4'd15, 4'd9, 4'd12, 1'b0);
    run_phase(4'd8, 4'd8, 4'd8, 1'b1);
    run_phase(4'd4, 4'd4, 4'd1, 1'b0);
    run_phase(4'd7, 4'd2, 4'd6, 1'b0);
    repeat (2) run_phase(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), 1'b0);

    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && results_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Output side: random stall before each word, one long hold on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        gap          = HoldCycles;
        hold_request = 1'b0;
      end else begin
        gap = $urandom_range(0, receiver_max_gap);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  // Watchdog: too long without any word moving on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/mma_pkg.sv
hdl/matrix_multiply_accumulate.sv
dv/matrix_multiply_accumulate_checker.sv
dv/matrix_multiply_accumulate_tb.sv
